/* rtl/overlay_outline_point_generator_defines.svh */
// Assertion macros for the overlay outline point generator checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef OVERLAY_OUTLINE_POINT_GENERATOR_DEFINES_SVH
`define OVERLAY_OUTLINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define OOPG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oopg: same-cycle check failed");

// Next-cycle implication.
`define OOPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oopg: next-cycle check failed");

`endif

/* rtl/oopg_pkg.sv */
// Shared constants and types of the overlay outline point generator.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package oopg_pkg;

  localparam int unsigned SENSOR_WIDTH        = 188;
  localparam int unsigned SENSOR_HEIGHT       = 120;
  localparam int unsigned MAX_OUTLINES        = 5;
  localparam int unsigned POINT_COUNT_DEFAULT = 120;

  // cropped image window
  localparam int unsigned IMG_W    = (SENSOR_WIDTH / 8) * 8;
  localparam int unsigned IMG_H    = SENSOR_HEIGHT;
  localparam int unsigned IMG_XOFF = (SENSOR_WIDTH - IMG_W) / 2;

  localparam int unsigned COORD_W    = 8;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned PAIR_W     = 6;
  localparam int unsigned OUT_X_W    = 8;
  localparam int unsigned OUT_Y_W    = 7;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_QUAD  = 2'd2
  } kind_e;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PAIR_W-1:0] pair;
    logic              last;
    logic              odd_ok;
    logic              quad;
  } meta_t;

endpackage

/* rtl/overlay_outline_point_generator.sv */
// Overlay outline point generator: line / quadrilateral items to clamped point pairs.
// Depends on oopg_pkg; checker oopg_checker is bound from its own file.
`timescale 1ns / 1ps

// Channel  Dir  Beat contents
// s_axis   in   tuser: kind; tdata: corner0_x .. corner3_y, 8 bits each
// m_axis   out  tdata: outline_index, pair_index, even/odd points; tlast: last_pair
//
// An accepted outline gives (POINT_COUNT+1)/2 beats, one per cycle unless the result beat stalls,
// set by the pair counter; the next item is taken in the cycle the last pair leaves the counter.
// Frame start, unused kind and items past the outline cap give no beats.
// After the accepting edge the first beat passes the product, estimate and result regs.
// Reset clears the outline count and empties the pipeline.
// A result beat waiting with m_axis_tready_i low freezes every stage and holds
// s_axis_tready_o low; with the result register empty the pipeline keeps moving.

module overlay_outline_point_generator #(
  parameter int unsigned POINT_COUNT = oopg_pkg::POINT_COUNT_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
  input  logic [oopg_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // kind
  input  logic [oopg_pkg::KIND_W-1:0]       s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // outline_index, pair_index, even_point_x, even_point_y, odd_point_x, odd_point_y, pad
  output logic [oopg_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // last_pair
  output logic                              m_axis_tlast_o
);

  localparam int unsigned PAIRS    = (POINT_COUNT + 1) / 2;
  localparam int unsigned EDGE_LEN = POINT_COUNT / 4;
  localparam int unsigned LINE_DEN = POINT_COUNT - 1;
  localparam int unsigned QUAD_DEN = EDGE_LEN - 1;
  localparam int unsigned NUM_W    = $clog2(POINT_COUNT + 1);
  localparam int unsigned PROD_W   = oopg_pkg::COORD_W + NUM_W;
  localparam int unsigned SHIFT    = PROD_W;
  localparam int unsigned M_W      = SHIFT + 1;
  localparam int unsigned LINE_M   = (2 ** SHIFT) / LINE_DEN;
  localparam int unsigned QUAD_M   = (2 ** SHIFT) / QUAD_DEN;
  localparam int unsigned SP_W     = $clog2(EDGE_LEN);

  localparam logic [oopg_pkg::PAIR_W-1:0] PAIR_LAST = oopg_pkg::PAIR_W'(PAIRS - 1);

  typedef struct packed {
    oopg_pkg::coord_t  a;
    logic              neg;
    logic [PROD_W-1:0] n;
  } lane1_t;

  typedef struct packed {
    oopg_pkg::coord_t  a;
    logic              neg;
    logic [PROD_W-1:0] n;
    oopg_pkg::coord_t  q0;
  } lane2_t;

  function automatic logic [oopg_pkg::OUT_X_W-1:0] clamp_x(input oopg_pkg::coord_t v);
    logic [oopg_pkg::COORD_W:0] v9;
    v9 = {1'b0, v};
    if (v9 <= 9'(oopg_pkg::IMG_XOFF)) begin
      return '0;
    end else if (v9 >= 9'(oopg_pkg::IMG_XOFF + oopg_pkg::IMG_W)) begin
      return oopg_pkg::OUT_X_W'(oopg_pkg::IMG_W - 1);
    end else begin
      return oopg_pkg::OUT_X_W'(v9 - 9'(oopg_pkg::IMG_XOFF));
    end
  endfunction

  function automatic logic [oopg_pkg::OUT_Y_W-1:0] clamp_y(input oopg_pkg::coord_t v);
    if ({1'b0, v} >= 9'(oopg_pkg::IMG_H)) begin
      return oopg_pkg::OUT_Y_W'(oopg_pkg::IMG_H - 1);
    end else begin
      return oopg_pkg::OUT_Y_W'(v);
    end
  endfunction

  // ---------------- input side and pair generator ----------------
  oopg_pkg::kind_e               kind;
  logic                          en, accept, start_outline, gen_fire, gen_last;
  logic                          busy_q, busy_d;
  logic [oopg_pkg::SLOT_W-1:0]   count_q, count_d;
  logic [oopg_pkg::SLOT_W-1:0]   slot_q;
  logic                          quad_q;
  logic [3:0][oopg_pkg::COORD_W-1:0] cx_q, cy_q;
  logic [oopg_pkg::PAIR_W-1:0]   k_q, k_d;
  logic [1:0]                    seg_q, seg_d, seg_odd;
  logic [SP_W-1:0]               sp_q, sp_d, sp_odd;
  logic [SP_W:0]                 sp1, sp2;

  assign kind          = oopg_pkg::kind_e'(s_axis_tuser_i);
  assign en            = !m_axis_tvalid_o || m_axis_tready_i;
  assign gen_last      = (k_q == PAIR_LAST);
  assign gen_fire      = busy_q && en;
  assign s_axis_tready_o = en && (!busy_q || gen_last);
  assign accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign start_outline = accept && ((kind == oopg_pkg::KIND_LINE) ||
                                    (kind == oopg_pkg::KIND_QUAD)) &&
                         (count_q < oopg_pkg::SLOT_W'(oopg_pkg::MAX_OUTLINES));

  // edge position of the odd point and of the next even point
  always_comb begin
    sp1 = (SP_W + 1)'(sp_q) + (SP_W + 1)'(1);
    sp2 = (SP_W + 1)'(sp_q) + (SP_W + 1)'(2);
    if (sp1 == (SP_W + 1)'(EDGE_LEN)) begin
      seg_odd = seg_q + 2'd1;
      sp_odd  = '0;
    end else begin
      seg_odd = seg_q;
      sp_odd  = SP_W'(sp1);
    end
  end

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    seg_d  = seg_q;
    sp_d   = sp_q;
    if (start_outline) begin
      busy_d = 1'b1;
      k_d    = '0;
      seg_d  = '0;
      sp_d   = '0;
    end else if (gen_fire) begin
      k_d = k_q + oopg_pkg::PAIR_W'(1);
      if (gen_last) begin
        busy_d = 1'b0;
      end
      if (sp2 >= (SP_W + 1)'(EDGE_LEN)) begin
        seg_d = seg_q + 2'd1;
        sp_d  = SP_W'(sp2 - (SP_W + 1)'(EDGE_LEN));
      end else begin
        sp_d  = SP_W'(sp2);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept && (kind == oopg_pkg::KIND_FRAME)) begin
      count_d = '0;
    end else if (start_outline) begin
      count_d = count_q + oopg_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      k_q     <= '0;
      seg_q   <= '0;
      sp_q    <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
      k_q     <= k_d;
      seg_q   <= seg_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_outline) begin
      slot_q <= count_q;
      quad_q <= (kind == oopg_pkg::KIND_QUAD);
      for (int v = 0; v < 4; v++) begin
        cx_q[v] <= s_axis_tdata_i[16*v +: 8];
        cy_q[v] <= s_axis_tdata_i[16*v + 8 +: 8];
      end
    end
  end

  // ---------------- lane setup: lanes are even x, even y, odd x, odd y ----------------
  logic [1:0]             seg_pt [2];
  logic [NUM_W-1:0]       numq_pt [2];
  logic [NUM_W-1:0]       numl_pt [2];
  logic [1:0]             seg_nx [2];
  oopg_pkg::coord_t       a_l [4];
  oopg_pkg::coord_t       b_l [4];
  logic [NUM_W-1:0]       num_l [4];
  logic [oopg_pkg::COORD_W:0] diff_l [4];
  oopg_pkg::coord_t       mag_l [4];
  oopg_pkg::meta_t        meta0;

  always_comb begin
    seg_pt[0]  = seg_q;
    seg_pt[1]  = seg_odd;
    numq_pt[0] = NUM_W'(sp_q);
    numq_pt[1] = NUM_W'(sp_odd);
    numl_pt[0] = NUM_W'({k_q, 1'b0});
    numl_pt[1] = NUM_W'({k_q, 1'b1});
    for (int pt = 0; pt < 2; pt++) begin
      seg_nx[pt] = seg_pt[pt] + 2'd1;
    end
    for (int i = 0; i < 4; i++) begin
      if (quad_q) begin
        a_l[i]   = (i[0]) ? cy_q[seg_pt[i >> 1]] : cx_q[seg_pt[i >> 1]];
        b_l[i]   = (i[0]) ? cy_q[seg_nx[i >> 1]] : cx_q[seg_nx[i >> 1]];
        num_l[i] = numq_pt[i >> 1];
      end else begin
        a_l[i]   = (i[0]) ? cy_q[0] : cx_q[0];
        b_l[i]   = (i[0]) ? cy_q[1] : cx_q[1];
        num_l[i] = numl_pt[i >> 1];
      end
      diff_l[i] = {1'b0, b_l[i]} - {1'b0, a_l[i]};
      mag_l[i]  = diff_l[i][oopg_pkg::COORD_W] ? oopg_pkg::COORD_W'(-diff_l[i])
                                               : diff_l[i][oopg_pkg::COORD_W-1:0];
    end
    meta0.slot   = slot_q;
    meta0.pair   = k_q;
    meta0.last   = gen_last;
    meta0.odd_ok = (8'({k_q, 1'b1}) < 8'(POINT_COUNT));
    meta0.quad   = quad_q;
  end

  // ---------------- stage 1: |delta| * step ----------------
  logic            v1_q;
  oopg_pkg::meta_t meta1_q;
  lane1_t          lane1_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta1_q <= meta0;
      for (int i = 0; i < 4; i++) begin
        lane1_q[i].a   <= a_l[i];
        lane1_q[i].neg <= diff_l[i][oopg_pkg::COORD_W];
        lane1_q[i].n   <= PROD_W'(mag_l[i]) * PROD_W'(num_l[i]);
      end
    end
  end

  // ---------------- stage 2: quotient estimate by reciprocal ----------------
  logic            v2_q;
  oopg_pkg::meta_t meta2_q;
  lane2_t          lane2_q [4];
  logic [M_W-1:0]  recip;
  logic [PROD_W+M_W-1:0] est_l [4];

  always_comb begin
    recip = meta1_q.quad ? M_W'(QUAD_M) : M_W'(LINE_M);
    for (int i = 0; i < 4; i++) begin
      est_l[i] = (PROD_W + M_W)'(lane1_q[i].n) * (PROD_W + M_W)'(recip);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta2_q <= meta1_q;
      for (int i = 0; i < 4; i++) begin
        lane2_q[i].a   <= lane1_q[i].a;
        lane2_q[i].neg <= lane1_q[i].neg;
        lane2_q[i].n   <= lane1_q[i].n;
        lane2_q[i].q0  <= oopg_pkg::COORD_W'(est_l[i] >> SHIFT);
      end
    end
  end

  // ---------------- stage 3: correct quotient, apply sign, crop and clamp ----------------
  logic [PROD_W-1:0]          den;
  logic [PROD_W-1:0]          rem_l [4];
  logic [oopg_pkg::COORD_W:0] quo_l [4];
  logic [oopg_pkg::COORD_W:0] val_l [4];
  logic [oopg_pkg::OUT_X_W-1:0] ex, ox;
  logic [oopg_pkg::OUT_Y_W-1:0] ey, oy;
  logic [oopg_pkg::OUT_DATA_W-1:0] out_data_d, out_data_q;
  logic                       out_valid_q, out_last_q;

  always_comb begin
    den = meta2_q.quad ? PROD_W'(QUAD_DEN) : PROD_W'(LINE_DEN);
    for (int i = 0; i < 4; i++) begin
      // estimate is low by at most one
      rem_l[i] = lane2_q[i].n - PROD_W'(lane2_q[i].q0) * den;
      quo_l[i] = {1'b0, lane2_q[i].q0} +
                 (oopg_pkg::COORD_W + 1)'(rem_l[i] >= den);
      val_l[i] = lane2_q[i].neg ? ({1'b0, lane2_q[i].a} - quo_l[i])
                                : ({1'b0, lane2_q[i].a} + quo_l[i]);
    end
    ex = clamp_x(val_l[0][oopg_pkg::COORD_W-1:0]);
    ey = clamp_y(val_l[1][oopg_pkg::COORD_W-1:0]);
    if (meta2_q.odd_ok) begin
      ox = clamp_x(val_l[2][oopg_pkg::COORD_W-1:0]);
      oy = clamp_y(val_l[3][oopg_pkg::COORD_W-1:0]);
    end else begin
      ox = '0;
      oy = '0;
    end
    out_data_d = {1'b0, oy, ox, ey, ex, meta2_q.pair, meta2_q.slot};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_last_q <= meta2_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* rtl/oopg_checker.sv */
// Port-level checker for the overlay outline point generator, bound to the top level.
// Depends on oopg_pkg and overlay_outline_point_generator_defines.svh.
`timescale 1ns / 1ps
`include "overlay_outline_point_generator_defines.svh"

module oopg_checker #(
  parameter int unsigned POINT_COUNT = oopg_pkg::POINT_COUNT_DEFAULT
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tready_i,
  input logic                            m_tvalid_i,
  input logic                            m_tready_i,
  input logic [oopg_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input logic                            m_tlast_i
);

  localparam logic [oopg_pkg::PAIR_W-1:0] PAIR_LAST =
    oopg_pkg::PAIR_W'((POINT_COUNT + 1) / 2 - 1);

  logic [oopg_pkg::SLOT_W-1:0] slot;
  logic [oopg_pkg::PAIR_W-1:0] pair;
  logic [oopg_pkg::OUT_X_W-1:0] ex;

  assign slot = m_tdata_i[2:0];
  assign pair = m_tdata_i[8:3];
  assign ex   = m_tdata_i[16:9];

  // a stalled beat holds, and the whole pipeline stops taking input meanwhile
  `OOPG_ASSERT_NEXT(a_out_hold, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))
  `OOPG_ASSERT_IMPLY(a_stall_blocks_in, m_tvalid_i && !m_tready_i, !s_tready_i)
  // pairs of one outline leave back to back in order
  `OOPG_ASSERT_NEXT(a_pair_step, m_tvalid_i && m_tready_i && !m_tlast_i, m_tvalid_i && (pair == $past(pair) + 6'd1))
  `OOPG_ASSERT_IMPLY(a_last_pair, m_tvalid_i, (m_tlast_i == (pair == PAIR_LAST)) && (slot < oopg_pkg::SLOT_W'(oopg_pkg::MAX_OUTLINES)) && (ex < oopg_pkg::OUT_X_W'(oopg_pkg::IMG_W)) && !m_tdata_i[39])

endmodule

bind overlay_outline_point_generator oopg_checker #(
  .POINT_COUNT(POINT_COUNT)
) u_oopg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);

/* dv/testbench.sv */
// Self-checking bench for overlay_outline_point_generator: random and directed outline
// beats in, every point-pair beat out compared against an in-bench outline predictor.
// Depends on oopg_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module testbench;
  import oopg_pkg::*;

  localparam int POINT_COUNT    = int'(POINT_COUNT_DEFAULT);
  localparam int EDGE_LEN       = POINT_COUNT / 4;
  localparam int PAIRS          = (POINT_COUNT + 1) / 2;
  localparam int CROP_W         = int'(IMG_W);
  localparam int CROP_H         = int'(IMG_H);
  localparam int CROP_XOFF      = int'(IMG_XOFF);
  localparam int RANDOM_ITEMS   = 300;
  localparam int DRAIN_SLACK    = 20;
  localparam int HOLD_START     = 3000;
  localparam int HOLD_LEN       = 600;

  // kind 3 has no package name; the block ignores it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // receiver stall modes
  localparam int READY_FULL   = 0;
  localparam int READY_MOSTLY = 1;
  localparam int READY_RARELY = 2;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [63:0]       corners;    // corner0_x in bits 7:0 .. corner3_y in bits 63:56
    bit                drain;      // sender waits for all points before offering this beat
  } outline_req_t;

  typedef struct {
    logic [SLOT_W-1:0]  outline;
    logic [PAIR_W-1:0]  pair;
    logic [OUT_X_W-1:0] ex;
    logic [OUT_Y_W-1:0] ey;
    logic [OUT_X_W-1:0] ox;
    logic [OUT_Y_W-1:0] oy;
    logic               last;
  } point_pair_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  outline_req_t req_q[$];
  point_pair_t  point_q[$];
  outline_req_t req_on_bus;
  point_pair_t  seen_pair;

  logic [SLOT_W-1:0] outline_slots = '0;
  bit   [7:0]        edge_coords[12] = '{0, 1, 2, 3, 4, 119, 120, 121, 185, 186, 187, 255};

  int error_count  = 0;
  int beats_in     = 0;
  int lines_seen   = 0;
  int quads_seen   = 0;
  int frames_seen  = 0;
  int capped_seen  = 0;
  int unused_seen  = 0;
  int pairs_seen   = 0;
  int gap_left     = 0;
  int burst_left   = 0;
  int ready_cycles = 0;
  int hold_left    = 0;
  int ready_mode   = READY_FULL;
  int mode_left    = 0;

  overlay_outline_point_generator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [OUT_X_W-1:0] crop_x(input int x);
    if (x <= CROP_XOFF) return '0;
    if (x >= CROP_XOFF + CROP_W) return OUT_X_W'(CROP_W - 1);
    return OUT_X_W'(x - CROP_XOFF);
  endfunction

  function automatic logic [OUT_Y_W-1:0] crop_y(input int y);
    if (y < 0) return '0;
    if (y >= CROP_H) return OUT_Y_W'(CROP_H - 1);
    return OUT_Y_W'(y);
  endfunction

  // int division truncates toward zero, as the block's magnitude divide with the sign applied after does
  function automatic void outline_point(input bit quad, input int vx[4], input int vy[4],
                                        input int p, output logic [OUT_X_W-1:0] px,
                                        output logic [OUT_Y_W-1:0] py);
    int seg, sp, nxt, x, y;
    if (!quad) begin
      x = vx[0] + ((vx[1] - vx[0]) * p) / (POINT_COUNT - 1);
      y = vy[0] + ((vy[1] - vy[0]) * p) / (POINT_COUNT - 1);
    end else begin
      seg = (p / EDGE_LEN) % 4;   // leftover points wrap back onto the first edge
      sp  = p % EDGE_LEN;
      nxt = (seg + 1) % 4;
      x = vx[seg] + ((vx[nxt] - vx[seg]) * sp) / (EDGE_LEN - 1);
      y = vy[seg] + ((vy[nxt] - vy[seg]) * sp) / (EDGE_LEN - 1);
    end
    px = crop_x(x);
    py = crop_y(y);
  endfunction

  function automatic void predict_outline(input outline_req_t req);
    int vx[4], vy[4];
    point_pair_t pp;
    beats_in++;
    if (req.kind == KIND_FRAME) begin
      outline_slots = '0;
      frames_seen++;
    end else if (req.kind == KIND_UNUSED) begin
      unused_seen++;
    end else if (outline_slots >= MAX_OUTLINES) begin
      capped_seen++;
    end else begin
      if (req.kind == KIND_QUAD) quads_seen++;
      else lines_seen++;
      for (int i = 0; i < 4; i++) begin
        vx[i] = int'(req.corners[16*i +: 8]);
        vy[i] = int'(req.corners[16*i+8 +: 8]);
      end
      for (int k = 0; k < PAIRS; k++) begin
        outline_point(req.kind == KIND_QUAD, vx, vy, 2*k, pp.ex, pp.ey);
        if (2*k + 1 < POINT_COUNT) begin
          outline_point(req.kind == KIND_QUAD, vx, vy, 2*k + 1, pp.ox, pp.oy);
        end else begin
          pp.ox = '0;
          pp.oy = '0;
        end
        pp.outline = outline_slots;
        pp.pair    = PAIR_W'(k);
        pp.last    = (k + 1 == PAIRS);
        point_q.push_back(pp);
      end
      outline_slots = outline_slots + 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      error_count++;
    end
  endfunction

  function automatic bit [7:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return edge_coords[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_req(input logic [KIND_W-1:0] kind, input logic [63:0] corners,
                                    input bit drain);
    outline_req_t req;
    req.kind    = kind;
    req.corners = corners;
    req.drain   = drain;
    req_q.push_back(req);
  endfunction

  function automatic logic [63:0] rand_corners();
    logic [63:0] c;
    for (int i = 0; i < 8; i++) c[8*i +: 8] = rand_coord();
    return c;
  endfunction

  // sender: bursts of random length, random gaps, holds a beat until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      if (s_tvalid && s_tready) predict_outline(req_on_bus);
      if (s_tvalid && !s_tready) begin
        // beat still waiting
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (req_q.size() == 0 || (req_q[0].drain && point_q.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        req_on_bus = req_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= req_on_bus.corners;
        s_tuser  <= req_on_bus.kind;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: stall pattern in segments, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      ready_cycles++;
      if (ready_cycles == HOLD_START) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(READY_FULL, READY_RARELY);
          mode_left  = $urandom_range(20, 300);
        end
        mode_left--;
        case (ready_mode)
          READY_FULL:   m_tready <= 1'b1;
          READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          default:      m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // tdata: outline_index, pair_index, even x/y, odd x/y from bit 0 up
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      pairs_seen++;
      if (point_q.size() == 0) begin
        $error("point-pair beat with nothing expected: tdata %h", m_tdata);
        error_count++;
      end else begin
        seen_pair = point_q.pop_front();
        check_field("outline_index", seen_pair.outline, m_tdata[2:0]);
        check_field("pair_index",    seen_pair.pair,    m_tdata[8:3]);
        check_field("even_point_x",  seen_pair.ex,      m_tdata[16:9]);
        check_field("even_point_y",  seen_pair.ey,      m_tdata[23:17]);
        check_field("odd_point_x",   seen_pair.ox,      m_tdata[31:24]);
        check_field("odd_point_y",   seen_pair.oy,      m_tdata[38:32]);
        check_field("last_pair",     seen_pair.last,    m_tlast);
      end
    end
  end

  initial begin
    int r;
    // directed: extremes, every kind, clamp edges, cap and frame restart
    queue_req(KIND_FRAME,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_req(KIND_LINE,   64'h0000_0000_FFFF_0000, 1'b0);
    queue_req(KIND_LINE,   64'hFFFF_FFFF_0000_FFFF, 1'b0);
    queue_req(KIND_LINE,   64'h0000_0000_00FF_FF00, 1'b0);
    queue_req(KIND_QUAD,   64'hFF00_FFFF_00FF_0000, 1'b0);
    queue_req(KIND_UNUSED, 64'hAAAA_5555_AAAA_5555, 1'b0);
    queue_req(KIND_QUAD,   rand_corners(),          1'b0);
    queue_req(KIND_LINE,   64'h0000_0000_78BA_7702, 1'b0);  // past the cap
    queue_req(KIND_QUAD,   64'hFFFF_0000_FFFF_0000, 1'b0);  // past the cap
    queue_req(KIND_UNUSED, 64'h0,                   1'b0);
    queue_req(KIND_FRAME,  64'h0,                   1'b1);
    queue_req(KIND_LINE,   64'h0000_0000_78BA_7702, 1'b0);  // x crop and y clamp edges
    queue_req(KIND_LINE,   64'h0000_0000_79BB_7603, 1'b0);
    queue_req(KIND_QUAD,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_req(KIND_QUAD,   64'h5555_5555_5555_5555, 1'b0);
    queue_req(KIND_QUAD,   64'h7879_BBBA_0302_0401, 1'b1);
    queue_req(KIND_FRAME,  64'hAAAA_AAAA_5555_5555, 1'b0);
    queue_req(KIND_LINE,   64'h0000_0000_4040_4040, 1'b0);  // zero-length line
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      queue_req(r < 12 ? KIND_FRAME : r < 15 ? KIND_UNUSED : r < 57 ? KIND_LINE : KIND_QUAD,
                rand_corners(), $urandom_range(0, 49) == 0);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_tvalid || point_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);

    $display("covered %0d input beats: %0d lines, %0d quads, %0d frame starts,",
             beats_in, lines_seen, quads_seen, frames_seen);
    $display("%0d over the cap, %0d unused kind; %0d point-pair beats checked",
             capped_seen, unused_seen, pairs_seen);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
